// File: rtl/pvt_pkg.sv
// types and constants shared by the peer vote tally threshold unit
// no dependencies
`default_nettype none

package pvt_pkg;

   localparam int SLOT_W     = 6;   // width of the peer slot field
   localparam int TIME_W     = 10;  // elapsed time in percent
   localparam int PCT_W      = 7;   // yes-weight threshold in percent
   localparam int COUNT_W    = 7;   // yes and no counts
   localparam int CSR_IDX_W  = 4;   // register index, room for unused codes
   localparam int CSR_DATA_W = 10;  // widest register
   localparam int PCT_SCALE  = 100;

   typedef enum logic [1:0] {
      REQ_SET    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MID_TIME   = 4'd0,
      CSR_LATE_TIME  = 4'd1,
      CSR_STUCK_TIME = 4'd2,
      CSR_INIT_PCT   = 4'd3,
      CSR_MID_PCT    = 4'd4,
      CSR_LATE_PCT   = 4'd5,
      CSR_STUCK_PCT  = 4'd6,
      CSR_OWN_VOTE   = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2
   } state_type;

endpackage

`default_nettype wire

// File: rtl/peer_vote_tally_threshold_unit.sv
// peer vote tally threshold unit: vote table, running counts, own vote update
// depends on pvt_pkg
`default_nettype none

// Tallies one yes/no vote per peer slot for a single disputed item and keeps
// our own vote. Each request beat is one of: set a peer vote, remove a peer
// vote, update our own vote (banded weighted threshold when proposing, plain
// majority otherwise), or an unused code that just reports the state. Every
// request beat yields exactly one response beat carrying vote_changed, our
// vote and the yes and no counts after the request. In the accept cycle the
// vote table (a single-port synchronous memory holding a present bit and a
// value bit per slot) is read; in the execute state, once the response
// register is free, the entry and the counts are updated and the response
// register is loaded. One request is in flight at a time, so the table write
// always lands before the next read; a new request beat can be taken while
// the previous response still waits in its register, and the execute cycle
// stalls only if that register is still full. Slots at or above PEER_SLOTS
// are ignored. After reset a clearing pass marks every table entry absent,
// one entry per cycle; req_ready stays low until it is done. Configuration
// beats are always accepted and must only arrive while no request is in
// flight; writing the own vote register loads our current vote directly.
module peer_vote_tally_threshold_unit
   import pvt_pkg::*;
#(
   parameter int PEER_SLOTS = 64
) (
   input  wire                    clock,
   input  wire                    reset,

   input  wire                    req_valid,
   output logic                   req_ready,
   input  wire  [1:0]             req_type,
   input  wire  [SLOT_W-1:0]      req_peer_slot,
   input  wire                    req_vote_yes,
   input  wire  [TIME_W-1:0]      req_percent_time,
   input  wire                    req_proposing,

   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic                   rsp_vote_changed,
   output logic                   rsp_own_vote,
   output logic [COUNT_W-1:0]     rsp_yes_count,
   output logic [COUNT_W-1:0]     rsp_no_count,

   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [TIME_W-1:0] mid_time_ff, late_time_ff, stuck_time_ff;
   logic [PCT_W-1:0]  init_pct_ff, mid_pct_ff, late_pct_ff, stuck_pct_ff;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_time_ff   <= TIME_W'(50);
         late_time_ff  <= TIME_W'(85);
         stuck_time_ff <= TIME_W'(200);
         init_pct_ff   <= PCT_W'(50);
         mid_pct_ff    <= PCT_W'(65);
         late_pct_ff   <= PCT_W'(70);
         stuck_pct_ff  <= PCT_W'(95);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_MID_TIME:   mid_time_ff   <= csr_data;
            CSR_LATE_TIME:  late_time_ff  <= csr_data;
            CSR_STUCK_TIME: stuck_time_ff <= csr_data;
            CSR_INIT_PCT:   init_pct_ff   <= csr_data[PCT_W-1:0];
            CSR_MID_PCT:    mid_pct_ff    <= csr_data[PCT_W-1:0];
            CSR_LATE_PCT:   late_pct_ff   <= csr_data[PCT_W-1:0];
            CSR_STUCK_PCT:  stuck_pct_ff  <= csr_data[PCT_W-1:0];
            CSR_OWN_VOTE:   ;  // loads our vote directly, see below
            default:        ;  // unused register index
         endcase
      end
   end

   // ------------------------------------------------------------------
   // control
   // ------------------------------------------------------------------
   state_type        state_ff, state_in;
   logic             req_accept;
   logic             commit;           // execute cycle finishes this cycle
   logic             clearing;         // clearing pass writes one entry
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] clr_idx_ff;
   logic             clr_last;

   assign req_accept = req_valid & req_ready;
   assign clr_last   = 32'(clr_idx_ff) == 32'(PEER_SLOTS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last)   state_in = ST_IDLE;
         ST_IDLE:  if (req_accept) state_in = ST_EXEC;
         ST_EXEC:  if (commit)     state_in = ST_IDLE;
         default:                  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      clearing  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clearing  = 1'b1;
         ST_IDLE:  req_ready = 1'b1;
         ST_EXEC:  commit    = ~rsp_valid_ff | rsp_ready;  // response register free
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clearing)
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
      end
   end

   // ------------------------------------------------------------------
   // request capture and table read
   // ------------------------------------------------------------------
   req_kind_type      kind_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              vote_yes_ff;
   logic [TIME_W-1:0] pct_time_ff;
   logic              proposing_ff;

   logic [EXT_W-1:0]  req_slot_ext, slot_ext;
   logic [IDX_W-1:0]  req_idx, slot_idx;
   logic              slot_in_range;

   assign req_slot_ext  = EXT_W'(req_peer_slot);
   assign req_idx       = req_slot_ext[IDX_W-1:0];
   assign slot_ext      = EXT_W'(slot_ff);
   assign slot_idx      = slot_ext[IDX_W-1:0];
   assign slot_in_range = 32'(slot_ff) < 32'(PEER_SLOTS);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff      <= req_kind_type'(req_type);
         slot_ff      <= req_peer_slot;
         vote_yes_ff  <= req_vote_yes;
         pct_time_ff  <= req_percent_time;
         proposing_ff <= req_proposing;
      end
   end

   // vote table, present bit over value bit per slot, read in the accept cycle
   logic [1:0]       tbl_mem [PEER_SLOTS];
   logic [1:0]       tbl_rd_ff;
   logic             tbl_we;
   logic [IDX_W-1:0] tbl_addr;
   logic [1:0]       tbl_wdata;
   logic             mem_we;
   logic [1:0]       mem_wdata;
   logic             pres_rd, val_rd;

   assign tbl_we    = clearing | mem_we;
   assign tbl_addr  = clearing ? clr_idx_ff : slot_idx;
   assign tbl_wdata = clearing ? 2'b00 : mem_wdata;
   assign pres_rd   = tbl_rd_ff[1];
   assign val_rd    = tbl_rd_ff[0];

   always_ff @(posedge clock) begin
      if (tbl_we)
         tbl_mem[tbl_addr] <= tbl_wdata;
      if (req_accept)
         tbl_rd_ff <= tbl_mem[req_idx];
   end

   // ------------------------------------------------------------------
   // counts and own vote
   // ------------------------------------------------------------------
   logic [COUNT_W-1:0] yes_ff, yes_in, no_ff, no_in;
   logic               own_ff, own_in;
   logic               changed;

   // threshold for the band that the elapsed time falls in
   logic [PCT_W-1:0]   need;
   always_comb begin
      priority if (pct_time_ff < mid_time_ff)   need = init_pct_ff;
      else if     (pct_time_ff < late_time_ff)  need = mid_pct_ff;
      else if     (pct_time_ff < stuck_time_ff) need = late_pct_ff;
      else                                      need = stuck_pct_ff;
   end

   // floor(100*(yes+own) / (yes+no+1)) > need  <=>  100*(yes+own) >= (need+1)*(yes+no+1)
   logic [7:0]  need_p1;
   logic [7:0]  den;
   logic [7:0]  yes_own;
   logic [15:0] prod;
   logic [15:0] num;
   logic        weight_above;

   assign need_p1      = 8'(need) + 8'd1;
   assign den          = 8'(yes_ff) + 8'(no_ff) + 8'd1;
   assign yes_own      = 8'(yes_ff) + 8'(own_ff);
   assign prod         = 16'(need_p1) * 16'(den);
   assign num          = 16'(yes_own) * 16'(PCT_SCALE);
   assign weight_above = num >= prod;

   logic next_vote;
   always_comb begin
      if (proposing_ff)
         next_vote = weight_above;
      else
         next_vote = yes_ff > no_ff;
   end

   always_comb begin
      yes_in    = yes_ff;
      no_in     = no_ff;
      own_in    = own_ff;
      changed   = 1'b0;
      mem_we    = 1'b0;
      mem_wdata = {1'b1, vote_yes_ff};
      if (commit) begin
         unique case (kind_ff)
            REQ_SET: begin
               if (slot_in_range) begin
                  if (!pres_rd) begin
                     // new vote
                     mem_we = 1'b1;
                     if (vote_yes_ff) yes_in = yes_ff + COUNT_W'(1);
                     else             no_in  = no_ff + COUNT_W'(1);
                  end else if (vote_yes_ff != val_rd) begin
                     // vote flips, counts move across
                     mem_we = 1'b1;
                     if (vote_yes_ff) begin
                        yes_in = yes_ff + COUNT_W'(1);
                        no_in  = no_ff - COUNT_W'(1);
                     end else begin
                        yes_in = yes_ff - COUNT_W'(1);
                        no_in  = no_ff + COUNT_W'(1);
                     end
                  end
               end
            end
            REQ_REMOVE: begin
               if (slot_in_range && pres_rd) begin
                  mem_we    = 1'b1;
                  mem_wdata = 2'b00;
                  if (val_rd) yes_in = yes_ff - COUNT_W'(1);
                  else        no_in  = no_ff - COUNT_W'(1);
               end
            end
            REQ_UPDATE: begin
               // no opposition keeps the vote as it is
               if (!((own_ff && no_ff == '0) || (!own_ff && yes_ff == '0))) begin
                  if (next_vote != own_ff) begin
                     own_in  = next_vote;
                     changed = 1'b1;
                  end
               end
            end
            REQ_NONE: ;
            default: ;
         endcase
      end
      if (csr_write && csr_index_type'(csr_index) == CSR_OWN_VOTE)
         own_in = csr_data[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yes_ff <= '0;
         no_ff  <= '0;
         own_ff <= 1'b0;
      end else begin
         yes_ff <= yes_in;
         no_ff  <= no_in;
         own_ff <= own_in;
      end
   end

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   logic               rsp_changed_ff;
   logic               rsp_own_ff;
   logic [COUNT_W-1:0] rsp_yes_ff, rsp_no_ff;

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_changed_ff <= changed;
         rsp_own_ff     <= own_in;
         rsp_yes_ff     <= yes_in;
         rsp_no_ff      <= no_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vote_changed = rsp_changed_ff;
   assign rsp_own_vote     = rsp_own_ff;
   assign rsp_yes_count    = rsp_yes_ff;
   assign rsp_no_count     = rsp_no_ff;

endmodule

`default_nettype wire
